// ===== sv/u16u8_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder package
// Shared types and constants for the front classifier, the queue and the
// byte serializer.
// ----------------------------------------------------------------------------
package u16u8_pkg;

    // Error codes carried with every result byte.
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_LONE_LOW  = 2'd1;
    localparam logic [1:0] ERR_UNPAIRED  = 2'd2;
    localparam logic [1:0] ERR_END_HIGH  = 2'd3;

    // Code unit boundaries.
    localparam logic [15:0] LIM_ONE_BYTE = 16'h0080;
    localparam logic [15:0] LIM_TWO_BYTE = 16'h0800;
    localparam logic [15:0] SURR_HIGH    = 16'hd800;
    localparam logic [15:0] SURR_LOW     = 16'hdc00;
    localparam logic [15:0] SURR_END     = 16'he000;

    // Lead and continuation byte marks.
    localparam logic [7:0]  LEAD_TWO     = 8'hc0;
    localparam logic [7:0]  LEAD_THREE   = 8'he0;
    localparam logic [7:0]  LEAD_FOUR    = 8'hf0;
    localparam logic [7:0]  CONT_MARK    = 8'h80;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;

    // One queued run: up to four bytes, the index of the last byte, and the
    // flags that go with the last byte.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            str_end;
        logic [1:0]      err;
    } run_t;

    // Push request from the front to the queue.
    typedef struct packed {
        logic push;
        run_t run;
    } push_t;

endpackage

// ===== sv/utf16_to_utf8_encoder.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder
// The first byte of a unit is offered from the queue's registered head.
// Throughput: one output byte per cycle while m_tready is high, so a unit
// gives one to four bytes (a held high surrogate takes one input beat and no
// output); the rate is set by the single-byte output serializer.
// Reset: aresetn clears the surrogate hold, the queue and the byte index.
// ----------------------------------------------------------------------------
//
// Structure: the front classifies each code unit and builds a complete run
// of result bytes combinationally. Runs wait in a short queue, so the input side
// keeps taking units while the serializer is still sending earlier bytes.
// The serializer sends the head run byte by byte and retires it on the beat
// of its last byte.
module utf16_to_utf8_encoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] code_unit
    input  logic        s_tlast,   // final_unit
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,   // string_end
    output logic [2:0]  m_tuser    // [0] run_last, [2:1] error_kind
);

    u16u8_pkg::push_t req;
    u16u8_pkg::run_t  head;
    logic             full;
    logic             head_valid;
    logic             pop;
    logic             s_accept;
    logic             run_last;
    logic [1:0]       error_kind;

    // Every accepted unit makes at most one run, so a free queue slot is all
    // the front needs to take a beat.
    assign s_tready = !full;
    assign s_accept = s_tvalid && s_tready;

    u16u8_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (s_accept),
        .code_unit  (s_tdata),
        .final_unit (s_tlast),
        .req        (req)
    );

    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (req),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head       (head)
    );

    u16u8_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .out_byte   (m_tdata),
        .run_last   (run_last),
        .string_end (m_tlast),
        .error_kind (error_kind)
    );

    assign m_tuser = {error_kind, run_last};

endmodule

// ===== sv/u16u8_front.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 front classifier
// Accepts code units, tracks a held high surrogate and turns each other unit into
// one run of result bytes for the queue.
// ----------------------------------------------------------------------------
module u16u8_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [15:0]         code_unit,
    input  logic                final_unit,
    output u16u8_pkg::push_t    req
);

    logic       pending_reg, pending_next;
    logic [9:0] payload_reg, payload_next;

    logic        is_high, is_low;
    logic [20:0] cp;

    assign is_high = (code_unit >= u16u8_pkg::SURR_HIGH) && (code_unit < u16u8_pkg::SURR_LOW);
    assign is_low  = (code_unit >= u16u8_pkg::SURR_LOW)  && (code_unit < u16u8_pkg::SURR_END);
    assign cp      = {1'b0, payload_reg, code_unit[9:0]} + u16u8_pkg::SUPP_BASE;

    always_comb begin
        pending_next         = pending_reg;
        payload_next         = payload_reg;
        req.push             = 1'b0;
        req.run.bytes        = '0;
        req.run.last_idx     = 2'd0;
        req.run.str_end      = final_unit;
        req.run.err          = u16u8_pkg::ERR_NONE;
        if (accept) begin
            req.push = 1'b1;
            if (pending_reg) begin
                pending_next = 1'b0;
                if (is_low) begin
                    req.run.bytes[0] = u16u8_pkg::LEAD_FOUR | {5'd0, cp[20:18]};
                    req.run.bytes[1] = u16u8_pkg::CONT_MARK | {2'd0, cp[17:12]};
                    req.run.bytes[2] = u16u8_pkg::CONT_MARK | {2'd0, cp[11:6]};
                    req.run.bytes[3] = u16u8_pkg::CONT_MARK | {2'd0, cp[5:0]};
                    req.run.last_idx = 2'd3;
                end else begin
                    req.run.err = u16u8_pkg::ERR_UNPAIRED;
                end
            end else if (code_unit < u16u8_pkg::LIM_ONE_BYTE) begin
                req.run.bytes[0] = code_unit[7:0];
            end else if (code_unit < u16u8_pkg::LIM_TWO_BYTE) begin
                req.run.bytes[0] = u16u8_pkg::LEAD_TWO  | {3'd0, code_unit[10:6]};
                req.run.bytes[1] = u16u8_pkg::CONT_MARK | {2'd0, code_unit[5:0]};
                req.run.last_idx = 2'd1;
            end else if (is_high) begin
                if (final_unit) begin
                    req.run.err = u16u8_pkg::ERR_END_HIGH;
                end else begin
                    // Hold the surrogate; it produces nothing on its own.
                    req.push     = 1'b0;
                    pending_next = 1'b1;
                    payload_next = code_unit[9:0];
                end
            end else if (is_low) begin
                req.run.err = u16u8_pkg::ERR_LONE_LOW;
            end else begin
                req.run.bytes[0] = u16u8_pkg::LEAD_THREE | {4'd0, code_unit[15:12]};
                req.run.bytes[1] = u16u8_pkg::CONT_MARK  | {2'd0, code_unit[11:6]};
                req.run.bytes[2] = u16u8_pkg::CONT_MARK  | {2'd0, code_unit[5:0]};
                req.run.last_idx = 2'd2;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b0;
        end else begin
            pending_reg <= pending_next;
        end
        payload_reg <= payload_next;
    end

endmodule

// ===== sv/u16u8_queue.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 run queue
// Small first-word-fall-through queue of byte runs between the front and the
// serializer.
// ----------------------------------------------------------------------------
module u16u8_queue #(
    parameter int DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  u16u8_pkg::push_t    req,
    input  logic                pop,
    output logic                full,
    output logic                head_valid,
    output u16u8_pkg::run_t     head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    u16u8_pkg::run_t  mem [DEPTH];
    u16u8_pkg::run_t  head_reg;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = head_reg;
    assign do_push    = req.push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // The head register always holds the entry at the next read pointer. A
    // run written into that very slot in this cycle is passed straight on.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= req.run;
        end
        if (do_push && (wr_ptr_reg == rd_ptr_next)) begin
            head_reg <= req.run;
        end else begin
            head_reg <= mem[rd_ptr_next];
        end
    end

endmodule

// ===== sv/u16u8_back.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 byte serializer
// Walks the run at the head of the queue one byte per beat and frees the
// entry when its last byte is taken.
// ----------------------------------------------------------------------------
module u16u8_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  u16u8_pkg::run_t     head,
    output logic                pop,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [7:0]          out_byte,
    output logic                run_last,
    output logic                string_end,
    output logic [1:0]          error_kind
);

    logic [1:0] idx_reg, idx_next;
    logic       take;

    assign m_tvalid   = head_valid;
    assign out_byte   = head.bytes[idx_reg];
    assign run_last   = (idx_reg == head.last_idx);
    assign string_end = run_last && head.str_end;
    assign error_kind = head.err;
    assign take       = head_valid && m_tready;
    assign pop        = take && run_last;

    always_comb begin
        idx_next = idx_reg;
        if (take) begin
            idx_next = run_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 2'd0;
        end else begin
            idx_reg <= idx_next;
        end
    end

endmodule
